### design/gdas_pkg.sv
// Shared types, constants, tables and microcode for the date add/subtract block.
package gdas_pkg;

    localparam int YEAR_W           = 14;
    localparam int MONTH_W          = 4;
    localparam int DAY_W            = 5;
    localparam int DAY_COUNT_W      = 20;
    localparam int DAY_COUNT_BITS_DEF = 20;
    localparam int DAY_NUM_W        = 22;
    localparam int PC_W             = 6;
    localparam int WIDX_W           = 4;

    localparam logic [YEAR_W-1:0]    YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0]   MONTH_MAX = 4'd12;
    localparam logic [DAY_NUM_W-1:0] DAY_LIMIT = 22'd3652059;

    localparam logic [PC_W-1:0] WAIT_PC  = 6'd0;
    localparam logic [PC_W-1:0] MWALK_PC = 6'd32;
    localparam logic [PC_W-1:0] EMIT_PC  = 6'd33;

    typedef struct packed {
        logic                   req_type;
        logic [YEAR_W-1:0]      in_year;
        logic [MONTH_W-1:0]     in_month;
        logic [DAY_W-1:0]       in_day;
        logic [DAY_COUNT_W-1:0] day_count;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic               range_error;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,
        OP_CHKY  = 3'd1,
        OP_FSTEP = 3'd2,
        OP_DOY   = 3'd3,
        OP_ADD   = 3'd4,
        OP_BSTEP = 3'd5,
        OP_MWALK = 3'd6,
        OP_EMIT  = 3'd7
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WIDX_W-1:0] widx;
        logic [PC_W-1:0]   jmp;
    } ctrl_t;

    typedef struct packed {
        logic hold;
        logic jump;
    } stat_t;

    typedef enum logic [1:0] {
        G400 = 2'd0,
        G100 = 2'd1,
        G4   = 2'd2,
        G1   = 2'd3
    } grp_t;

    typedef struct packed {
        logic [YEAR_W-1:0]    yw;
        logic [DAY_NUM_W-1:0] dw;
        grp_t                 grp;
        logic [2:0]           qbit;
    } wt_t;

    // Paired year and day weights, largest first, for the restoring steps.
    function automatic wt_t weight(input logic [WIDX_W-1:0] idx);
        wt_t w;
        w = '{14'd0, 22'd0, G400, 3'd0};
        unique case (idx)
            4'd0:  w = '{14'd6400, 22'd2337552, G400, 3'd4};
            4'd1:  w = '{14'd3200, 22'd1168776, G400, 3'd3};
            4'd2:  w = '{14'd1600, 22'd584388,  G400, 3'd2};
            4'd3:  w = '{14'd800,  22'd292194,  G400, 3'd1};
            4'd4:  w = '{14'd400,  22'd146097,  G400, 3'd0};
            4'd5:  w = '{14'd200,  22'd73048,   G100, 3'd1};
            4'd6:  w = '{14'd100,  22'd36524,   G100, 3'd0};
            4'd7:  w = '{14'd64,   22'd23376,   G4,   3'd4};
            4'd8:  w = '{14'd32,   22'd11688,   G4,   3'd3};
            4'd9:  w = '{14'd16,   22'd5844,    G4,   3'd2};
            4'd10: w = '{14'd8,    22'd2922,    G4,   3'd1};
            4'd11: w = '{14'd4,    22'd1461,    G4,   3'd0};
            4'd12: w = '{14'd2,    22'd730,     G1,   3'd1};
            4'd13: w = '{14'd1,    22'd365,     G1,   3'd0};
            default: w = '{14'd0, 22'd0, G400, 3'd0};
        endcase
        return w;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        unique case (m)
            4'd2:  len = leap ? 5'd29 : 5'd28;
            4'd4:  len = 5'd30;
            4'd6:  len = 5'd30;
            4'd9:  len = 5'd30;
            4'd11: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Days before the first of month m in a common year.
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] c;
        c = 9'd0;
        unique case (m)
            4'd2:  c = 9'd31;
            4'd3:  c = 9'd59;
            4'd4:  c = 9'd90;
            4'd5:  c = 9'd120;
            4'd6:  c = 9'd151;
            4'd7:  c = 9'd181;
            4'd8:  c = 9'd212;
            4'd9:  c = 9'd243;
            4'd10: c = 9'd273;
            4'd11: c = 9'd304;
            4'd12: c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Microcode: date to day number, move, day number back to date.
    function automatic ctrl_t prog(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '{OP_WAIT, 4'd0, WAIT_PC};
        unique case (pc)
            6'd0:  c = '{OP_WAIT,  4'd0,  WAIT_PC};
            6'd1:  c = '{OP_CHKY,  4'd0,  EMIT_PC};
            6'd2:  c = '{OP_FSTEP, 4'd0,  WAIT_PC};
            6'd3:  c = '{OP_FSTEP, 4'd1,  WAIT_PC};
            6'd4:  c = '{OP_FSTEP, 4'd2,  WAIT_PC};
            6'd5:  c = '{OP_FSTEP, 4'd3,  WAIT_PC};
            6'd6:  c = '{OP_FSTEP, 4'd4,  WAIT_PC};
            6'd7:  c = '{OP_FSTEP, 4'd5,  WAIT_PC};
            6'd8:  c = '{OP_FSTEP, 4'd6,  WAIT_PC};
            6'd9:  c = '{OP_FSTEP, 4'd7,  WAIT_PC};
            6'd10: c = '{OP_FSTEP, 4'd8,  WAIT_PC};
            6'd11: c = '{OP_FSTEP, 4'd9,  WAIT_PC};
            6'd12: c = '{OP_FSTEP, 4'd10, WAIT_PC};
            6'd13: c = '{OP_FSTEP, 4'd11, WAIT_PC};
            6'd14: c = '{OP_FSTEP, 4'd12, WAIT_PC};
            6'd15: c = '{OP_FSTEP, 4'd13, WAIT_PC};
            6'd16: c = '{OP_DOY,   4'd0,  WAIT_PC};
            6'd17: c = '{OP_ADD,   4'd0,  EMIT_PC};
            6'd18: c = '{OP_BSTEP, 4'd0,  WAIT_PC};
            6'd19: c = '{OP_BSTEP, 4'd1,  WAIT_PC};
            6'd20: c = '{OP_BSTEP, 4'd2,  WAIT_PC};
            6'd21: c = '{OP_BSTEP, 4'd3,  WAIT_PC};
            6'd22: c = '{OP_BSTEP, 4'd4,  WAIT_PC};
            6'd23: c = '{OP_BSTEP, 4'd5,  WAIT_PC};
            6'd24: c = '{OP_BSTEP, 4'd6,  WAIT_PC};
            6'd25: c = '{OP_BSTEP, 4'd7,  WAIT_PC};
            6'd26: c = '{OP_BSTEP, 4'd8,  WAIT_PC};
            6'd27: c = '{OP_BSTEP, 4'd9,  WAIT_PC};
            6'd28: c = '{OP_BSTEP, 4'd10, WAIT_PC};
            6'd29: c = '{OP_BSTEP, 4'd11, WAIT_PC};
            6'd30: c = '{OP_BSTEP, 4'd12, WAIT_PC};
            6'd31: c = '{OP_BSTEP, 4'd13, WAIT_PC};
            6'd32: c = '{OP_MWALK, 4'd0,  MWALK_PC};
            6'd33: c = '{OP_EMIT,  4'd0,  WAIT_PC};
            default: c = '{OP_WAIT, 4'd0, WAIT_PC};
        endcase
        return c;
    endfunction

endpackage

### design/gdas_seq.sv
// Step counter and microcode table that sequence the datapath.
module gdas_seq
    import gdas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    assign ctrl = prog(pc_reg);

    always_comb
    begin
        priority if (stat.hold)
        begin
            pc_next = pc_reg;
        end
        else if (stat.jump)
        begin
            pc_next = ctrl.jmp;
        end
        else
        begin
            pc_next = pc_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= WAIT_PC;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

### design/gdas_dp.sv
// Datapath: year/day restoring unit, day-of-year and month walk, result register.
module gdas_dp
    import gdas_pkg::*;
#(
    parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    output stat_t stat,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req_item,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp_item
);

    localparam int CNT_W = (DAY_COUNT_BITS < DAY_COUNT_W) ? DAY_COUNT_BITS : DAY_COUNT_W;
    localparam int DN_W  = ((CNT_W > DAY_NUM_W) ? CNT_W : DAY_NUM_W) + 2;

    logic [YEAR_W-1:0]  y0_reg;
    logic [MONTH_W-1:0] m0_reg;
    logic [DAY_W-1:0]   d0_reg;
    logic               sub_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [YEAR_W-1:0]  yr_reg;
    logic [DN_W-1:0]    dn_reg;
    logic [MONTH_W-1:0] mo_reg;
    logic [1:0]         q100_reg;
    logic [4:0]         q4_reg;
    logic [1:0]         q1_reg;
    logic               err_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    wt_t              wt;
    logic             leap;
    logic [DAY_W-1:0] len;
    logic [DAY_W-1:0] dc;
    logic [DN_W-1:0]  dw_ext;
    logic [DN_W-1:0]  yw_ext;
    logic [DN_W-1:0]  sum;
    logic [DN_W-1:0]  doy;
    logic             add_fail;
    logic             yr_fail;
    logic             walk_more;
    logic             emit_go;
    logic             accept;
    logic             fstep_hit;
    logic             bstep_hit;

    assign req_stall = (ctrl.op != OP_WAIT);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    always_comb
    begin
        wt     = weight(ctrl.widx);
        dw_ext = DN_W'(wt.dw);
        yw_ext = DN_W'(wt.yw);
        // Leap year from the year-in-cycle decomposition of (year - 1).
        leap   = (q1_reg == 2'd3) && ((q4_reg != 5'd24) || (q100_reg == 2'd3));
        len    = month_len(leap, mo_reg);
        if (d0_reg == 5'd0)
        begin
            dc = 5'd1;
        end
        else if (d0_reg > len)
        begin
            dc = len;
        end
        else
        begin
            dc = d0_reg;
        end
        doy = DN_W'(cum_days(mo_reg)) + DN_W'(leap && (mo_reg > 4'd2))
            + DN_W'(dc - 5'd1);
        sum = sub_reg ? (dn_reg - DN_W'(cnt_reg)) : (dn_reg + DN_W'(cnt_reg));
        add_fail  = sum[DN_W-1] || (sum >= DN_W'(DAY_LIMIT));
        yr_fail   = (y0_reg == '0) || (y0_reg > YEAR_MAX);
        walk_more = (mo_reg < MONTH_MAX) && (dn_reg >= DN_W'(len));
        fstep_hit = (DN_W'(yr_reg) >= yw_ext);
        bstep_hit = (dn_reg >= dw_ext);
        emit_go   = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        stat.hold = 1'b0;
        stat.jump = 1'b0;
        unique case (ctrl.op)
            OP_WAIT:  stat.hold = !req_valid;
            OP_CHKY:  stat.jump = yr_fail;
            OP_FSTEP: stat.jump = 1'b0;
            OP_DOY:   stat.jump = 1'b0;
            OP_ADD:   stat.jump = add_fail;
            OP_BSTEP: stat.jump = 1'b0;
            OP_MWALK: stat.jump = walk_more;
            OP_EMIT:
            begin
                stat.hold = !emit_go;
                stat.jump = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_WAIT:
            begin
                if (accept)
                begin
                    y0_reg  <= req_item.in_year;
                    m0_reg  <= req_item.in_month;
                    d0_reg  <= req_item.in_day;
                    sub_reg <= req_item.req_type;
                    cnt_reg <= req_item.day_count[CNT_W-1:0];
                end
            end
            OP_CHKY:
            begin
                err_reg  <= yr_fail;
                yr_reg   <= y0_reg - 14'd1;
                dn_reg   <= '0;
                q100_reg <= '0;
                q4_reg   <= '0;
                q1_reg   <= '0;
                // Saturate the month into 1..12.
                if (m0_reg == 4'd0)
                begin
                    mo_reg <= 4'd1;
                end
                else if (m0_reg > MONTH_MAX)
                begin
                    mo_reg <= MONTH_MAX;
                end
                else
                begin
                    mo_reg <= m0_reg;
                end
            end
            OP_FSTEP, OP_BSTEP:
            begin
                if ((ctrl.op == OP_FSTEP) ? fstep_hit : bstep_hit)
                begin
                    if (ctrl.op == OP_FSTEP)
                    begin
                        yr_reg <= yr_reg - wt.yw;
                        dn_reg <= dn_reg + dw_ext;
                    end
                    else
                    begin
                        yr_reg <= yr_reg + wt.yw;
                        dn_reg <= dn_reg - dw_ext;
                    end
                    unique case (wt.grp)
                        G400: ;
                        G100: q100_reg <= q100_reg | (2'd1 << wt.qbit);
                        G4:   q4_reg   <= q4_reg   | (5'd1 << wt.qbit);
                        G1:   q1_reg   <= q1_reg   | (2'd1 << wt.qbit);
                    endcase
                end
            end
            OP_DOY:
            begin
                dn_reg <= dn_reg + doy;
            end
            OP_ADD:
            begin
                err_reg  <= add_fail;
                dn_reg   <= sum;
                yr_reg   <= 14'd1;
                mo_reg   <= 4'd1;
                q100_reg <= '0;
                q4_reg   <= '0;
                q1_reg   <= '0;
            end
            OP_MWALK:
            begin
                if (walk_more)
                begin
                    dn_reg <= dn_reg - DN_W'(len);
                    mo_reg <= mo_reg + 4'd1;
                end
            end
            OP_EMIT:
            begin
                if (emit_go)
                begin
                    if (err_reg)
                    begin
                        rsp_reg <= '{y0_reg, m0_reg, d0_reg, 1'b1};
                    end
                    else
                    begin
                        rsp_reg <= '{yr_reg, mo_reg, DAY_W'(dn_reg[DAY_W-1:0] + 5'd1), 1'b0};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((ctrl.op == OP_EMIT) && emit_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

endmodule

### design/gregorian_date_add_sub_days_top.sv
// Top level of the Gregorian date add/subtract-days block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  request  | req_valid / req_stall  | req_item: req_type, date, day_count
//  result   | rsp_valid / rsp_stall  | rsp_item: date, range_error
//
// An item passes from accept to result through a year check, 14 forward steps of the
// shared year/day subtract unit, a day-of-year step, the add, 14 backward steps, 1 to 12 month-walk
// steps and an emit step. A start year outside 1..9999 goes from the year check straight to the emit
// step, a moved date outside it from the add. Reset clears the step counter and the result valid;
// no clearing pass. A new item is accepted while the last result waits on rsp_stall; it then
// holds at its final step until the result register frees.
module gregorian_date_add_sub_days_top
    import gdas_pkg::*;
#(
    parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_item
);

    ctrl_t ctrl;
    stat_t stat;

    gdas_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    gdas_dp #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted but block not busy next cycle");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_item.range_error) |->
        (rsp_item.out_month >= 4'd1 && rsp_item.out_month <= 4'd12 &&
         rsp_item.out_day >= 5'd1 && rsp_item.out_year >= 14'd1 &&
         rsp_item.out_year <= 14'd9999))
        else $error("result date out of legal range");

    a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_item.range_error && rsp_item.out_month == 4'd2) |->
        (rsp_item.out_day <= 5'd29))
        else $error("February result past day 29");

    a_valid_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(!rsp_stall))
        else $error("result dropped without being taken");

endmodule
